@@ hw/rtl/bresenham_line_to_led_matrix_core_assert.svh @@
// assertion macros of the line rasterizer controller
`ifndef BRESENHAM_LINE_TO_LED_MATRIX_CORE_ASSERT_SVH
`define BRESENHAM_LINE_TO_LED_MATRIX_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BLMC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define BLMC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/blmc_pkg.sv @@
// shared types and constants of the line rasterizer
`timescale 1ns / 1ps

package blmc_pkg;

    localparam int COORD_W        = 6;
    localparam int DELTA_W        = COORD_W + 1;
    localparam int ERR_W          = 9;
    localparam int IDX_W          = 8;
    localparam int COLOUR_W       = 24;
    localparam int DISPLAY_WIDTH  = 24;
    localparam int DISPLAY_HEIGHT = 8;
    localparam int TILE_LOG2      = 3;
    localparam int CHAIN_BASE     = 64;
    localparam int IN_DATA_W      = 48;
    localparam int OUT_DATA_W     = 48;

    typedef enum logic [0:0] {
        S_IDLE,
        S_RUN
    } t_state;

    typedef struct packed {
        logic load;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic at_end;
    } t_dp_sts;

    typedef struct packed {
        logic [COLOUR_W-1:0] colour;
        logic                last;
        logic                visible;
        logic [IDX_W-1:0]    led_index;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  x;
    } t_point;

endpackage

@@ hw/rtl/blmc_ctrl.sv @@
// controller: line walk sequencing and output word handshake
`timescale 1ns / 1ps

`include "bresenham_line_to_led_matrix_core_assert.svh"

module blmc_ctrl
    import blmc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_valid,
    input  logic    i_m_ready,
    input  t_dp_sts i_sts,
    output logic    o_s_ready,
    output logic    o_m_valid,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_m_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (out_free && i_sts.at_end) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_ready  = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.emit = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_ready  = 1'b1;
                o_cmd.load = i_s_valid;
            end
            S_RUN: begin
                o_cmd.emit = out_free;
            end
            default: begin
                o_s_ready = 1'b0;
            end
        endcase
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_m_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_m_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `BLMC_ASSERT_IMPL(a_no_emit_idle, r_state == S_IDLE, !o_cmd.emit)
    `BLMC_ASSERT_NEXT(a_load_starts_run, o_cmd.load, r_state == S_RUN)
    `BLMC_ASSERT_NEXT(a_end_returns_idle, o_cmd.emit && i_sts.at_end,
                      r_state == S_IDLE && r_out_valid)
    `BLMC_ASSERT_IMPL(a_no_bubble, r_state == S_RUN && !r_out_valid, o_cmd.emit)

endmodule

@@ hw/rtl/blmc_dp.sv @@
// datapath: cursor, error term, led mapping and output register
`timescale 1ns / 1ps

module blmc_dp
    import blmc_pkg::*;
(
    input  logic                i_clk,
    input  logic [COORD_W-1:0]  i_start_x,
    input  logic [COORD_W-1:0]  i_start_y,
    input  logic [COORD_W-1:0]  i_end_x,
    input  logic [COORD_W-1:0]  i_end_y,
    input  logic [COLOUR_W-1:0] i_colour,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    output t_point              o_point
);

    localparam logic [IDX_W-1:0] BASE = IDX_W'(CHAIN_BASE);
    localparam logic [IDX_W-1:0] TILE_MASK = IDX_W'((1 << TILE_LOG2) - 1);

    logic [COORD_W-1:0]  r_cur_x;
    logic [COORD_W-1:0]  r_cur_y;
    logic [COORD_W-1:0]  r_tgt_x;
    logic [COORD_W-1:0]  r_tgt_y;
    logic [ERR_W-1:0]    r_err;
    logic [1:0]          r_step_signs;
    logic                r_x_major;
    logic [COLOUR_W-1:0] r_colour;
    logic [DELTA_W-1:0]  r_maj2;
    logic [DELTA_W-1:0]  r_min2;
    t_point              r_point;

    logic [DELTA_W-1:0]  dx;
    logic [DELTA_W-1:0]  dy;
    logic [COORD_W-1:0]  adx;
    logic [COORD_W-1:0]  ady;
    logic                ld_x_major;
    logic [COORD_W-1:0]  ld_maj;
    logic [COORD_W-1:0]  ld_min;
    logic [ERR_W-1:0]    ld_err;

    logic                err_ge;
    logic                step_x;
    logic                step_y;
    logic [COORD_W-1:0]  n_cur_x;
    logic [COORD_W-1:0]  n_cur_y;
    logic [ERR_W-1:0]    n_err;

    logic                vis;
    logic [IDX_W-1:0]    ux;
    logic [IDX_W-1:0]    uy;
    logic [IDX_W-1:0]    idx;
    t_point              n_point;

    // set-up of a new line
    always_comb begin
        dx = {i_end_x[COORD_W-1], i_end_x} - {i_start_x[COORD_W-1], i_start_x};
        dy = {i_end_y[COORD_W-1], i_end_y} - {i_start_y[COORD_W-1], i_start_y};
        adx = dx[DELTA_W-1] ? COORD_W'(-dx) : dx[COORD_W-1:0];
        ady = dy[DELTA_W-1] ? COORD_W'(-dy) : dy[COORD_W-1:0];
        ld_x_major = adx > ady;
        ld_maj = ld_x_major ? adx : ady;
        ld_min = ld_x_major ? ady : adx;
        ld_err = {2'b00, ld_min, 1'b0} - {3'b000, ld_maj};
    end

    // one step along the major axis
    always_comb begin
        err_ge  = !r_err[ERR_W-1];
        step_x  = r_x_major || err_ge;
        step_y  = !r_x_major || err_ge;
        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        if (step_x) begin
            n_cur_x = r_step_signs[0] ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
        end
        if (step_y) begin
            n_cur_y = r_step_signs[1] ? r_cur_y - 1'b1 : r_cur_y + 1'b1;
        end
        n_err = r_err + {2'b00, r_min2} - (err_ge ? {2'b00, r_maj2} : {ERR_W{1'b0}});
    end

    assign o_sts.at_end = r_x_major ? (r_cur_x == r_tgt_x) : (r_cur_y == r_tgt_y);

    // led chain mapping of the current point
    always_comb begin
        vis = !r_cur_x[COORD_W-1] && (r_cur_x < COORD_W'(DISPLAY_WIDTH)) &&
              !r_cur_y[COORD_W-1] && (r_cur_y < COORD_W'(DISPLAY_HEIGHT));
        ux  = IDX_W'(r_cur_x);
        uy  = IDX_W'(r_cur_y);
        idx = ((ux >> TILE_LOG2) << (2 * TILE_LOG2)) + (ux & TILE_MASK) +
              (uy << TILE_LOG2) + BASE;
        n_point.x         = r_cur_x;
        n_point.y         = r_cur_y;
        n_point.led_index = vis ? idx : {IDX_W{1'b0}};
        n_point.visible   = vis;
        n_point.last      = o_sts.at_end;
        n_point.colour    = r_colour;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur_x      <= i_start_x;
            r_cur_y      <= i_start_y;
            r_tgt_x      <= i_end_x;
            r_tgt_y      <= i_end_y;
            r_colour     <= i_colour;
            r_step_signs <= {dy[DELTA_W-1], dx[DELTA_W-1]};
            r_x_major    <= ld_x_major;
            r_maj2       <= {ld_maj, 1'b0};
            r_min2       <= {ld_min, 1'b0};
            r_err        <= ld_err;
        end else if (i_cmd.emit) begin
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            r_err   <= n_err;
        end
        if (i_cmd.emit) begin
            r_point <= n_point;
        end
    end

    assign o_point = r_point;

endmodule

@@ hw/rtl/bresenham_line_to_led_matrix_core.sv @@
// Line rasterizer onto a tiled LED chain: top level.
//
// Slave channel takes one line command per word: start and end points
// (6-bit two's complement) and a 24-bit colour. Master channel gives one
// word per point of the line, both end points included, with tlast on the
// final point. Each word carries the point, its LED chain index (tiles of
// 8x8 from LED 64), a visible flag for the 24x8 area and the colour.
// A command is taken only while no line is in progress; the next command
// word can be accepted from the cycle after the last point is registered.
// A command is loaded into the cursor registers; its first point goes into
// the output register once that is free. A line has N points (N is 1 to 64)
// and the walker issues one point a cycle while the receiver does not stall.
// A stall on the master side holds the output word and freezes the walker.
// Reset (i_rst_n low, synchronous) returns to idle and drops o_m_axis_tvalid.
`timescale 1ns / 1ps

module bresenham_line_to_led_matrix_core
    import blmc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // start_x, start_y, end_x, end_y, colour
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // point_x, point_y, led_index, visible, pixel_colour, zero pad
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic                  o_m_axis_tlast
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    t_point  point;

    blmc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .i_sts     (sts),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .o_cmd     (cmd)
    );

    blmc_dp u_dp (
        .i_clk     (i_clk),
        .i_start_x (i_s_axis_tdata[5:0]),
        .i_start_y (i_s_axis_tdata[11:6]),
        .i_end_x   (i_s_axis_tdata[17:12]),
        .i_end_y   (i_s_axis_tdata[23:18]),
        .i_colour  (i_s_axis_tdata[47:24]),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .o_point   (point)
    );

    assign o_m_axis_tdata = {3'b000, point.colour, point.visible, point.led_index,
                             point.y, point.x};
    assign o_m_axis_tlast = point.last;

endmodule

@@ tb/bresenham_line_to_led_matrix_core_tb.sv @@
// self-checking testbench of the line rasterizer: directed and random lines, checked point by point
`timescale 1ns / 1ps

module bresenham_line_to_led_matrix_core_tb;
    import blmc_pkg::*;

    localparam int N_RANDOM   = 420;
    localparam int IDLE_LIMIT = 3000;
    localparam int MAX_POINTS = 64;

    typedef struct {
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic [COLOUR_W-1:0]       colour;
        bit                        no_gap;
        bit                        drain;
    } t_line_cmd;

    logic                  i_clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tready = 1'b0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tlast;

    t_line_cmd line_queue[$];
    t_line_cmd on_bus;
    t_point    pending_points[$];

    int lines_total    = 0;
    int lines_accepted = 0;
    int words_taken    = 0;
    int mismatches     = 0;
    int src_gap        = 0;
    int rx_hold        = 0;
    int rx_cycles      = 0;
    int idle_cycles    = 0;
    bit long_hold_done = 1'b0;
    int r;

    bresenham_line_to_led_matrix_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // map one point onto the tiled chain and queue it
    function automatic void queue_point(logic signed [COORD_W-1:0] px,
                                        logic signed [COORD_W-1:0] py,
                                        logic [COLOUR_W-1:0] colour, logic at_end);
        t_point p;
        logic [COORD_W-1:0] ux;
        logic [COORD_W-1:0] uy;
        ux = px;
        uy = py;
        p.x       = px;
        p.y       = py;
        p.colour  = colour;
        p.last    = at_end;
        p.visible = (px >= 0) && (px < DISPLAY_WIDTH) && (py >= 0) && (py < DISPLAY_HEIGHT);
        p.led_index = '0;
        if (p.visible) begin
            p.led_index = IDX_W'((ux >> TILE_LOG2) * 64 + (ux & 6'd7) + uy * 8 + CHAIN_BASE);
        end
        pending_points.push_back(p);
    endfunction

    // walk the line from start to end with the doubled-delta error term
    function automatic void walk_line(t_line_cmd c);
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [ERR_W-1:0]   ddx;
        logic signed [ERR_W-1:0]   ddy;
        logic signed [ERR_W-1:0]   err;
        logic neg_x;
        logic neg_y;
        logic x_maj;
        int n;
        cx = c.x0;
        cy = c.y0;
        ddx = ERR_W'(c.x1) - ERR_W'(c.x0);
        ddy = ERR_W'(c.y1) - ERR_W'(c.y0);
        neg_x = ddx < 0;
        neg_y = ddy < 0;
        if (neg_x) ddx = -ddx;
        if (neg_y) ddy = -ddy;
        ddx = ddx <<< 1;
        ddy = ddy <<< 1;
        x_maj = ddx > ddy;
        err = x_maj ? ddy - (ddx >>> 1) : ddx - (ddy >>> 1);
        queue_point(cx, cy, c.colour, x_maj ? (cx == c.x1) : (cy == c.y1));
        n = 1;
        while (n < MAX_POINTS && (x_maj ? (cx != c.x1) : (cy != c.y1))) begin
            if (x_maj) begin
                if (err >= 0) begin
                    cy = neg_y ? cy - 6'sd1 : cy + 6'sd1;
                    err = err - ddx;
                end
                cx = neg_x ? cx - 6'sd1 : cx + 6'sd1;
                err = err + ddy;
                queue_point(cx, cy, c.colour, cx == c.x1);
            end else begin
                if (err >= 0) begin
                    cx = neg_x ? cx - 6'sd1 : cx + 6'sd1;
                    err = err - ddy;
                end
                cy = neg_y ? cy - 6'sd1 : cy + 6'sd1;
                err = err + ddx;
                queue_point(cx, cy, c.colour, cy == c.y1);
            end
            n++;
        end
    endfunction

    function automatic void add_line(int x0, int y0, int x1, int y1, logic [COLOUR_W-1:0] colour,
                                     bit no_gap, bit drain);
        t_line_cmd c;
        c.x0 = COORD_W'(x0);
        c.y0 = COORD_W'(y0);
        c.x1 = COORD_W'(x1);
        c.y1 = COORD_W'(y1);
        c.colour = colour;
        c.no_gap = no_gap;
        c.drain  = drain;
        line_queue.push_back(c);
        lines_total++;
    endfunction

    function automatic int pick(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic int next_gap(bit no_gap);
        int g;
        g = $urandom_range(99);
        if (no_gap || g < 55) return 0;
        if (g < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 30);
    endfunction

    function automatic void check_word(logic [OUT_DATA_W-1:0] d, logic tl);
        t_point e;
        logic signed [COORD_W-1:0] gx;
        logic signed [COORD_W-1:0] gy;
        gx = d[5:0];
        gy = d[11:6];
        if (pending_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected word: x=%0d y=%0d idx=%0d", gx, gy, d[19:12]);
            end
            return;
        end
        e = pending_points.pop_front();
        if (gx != e.x || gy != e.y || d[19:12] != e.led_index || d[20] != e.visible ||
            d[44:21] != e.colour || tl != e.last) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: expected x=%0d y=%0d idx=%0d vis=%0b col=%06h last=%0b",
                         $signed(e.x), $signed(e.y), e.led_index, e.visible, e.colour, e.last);
                $display("          got      x=%0d y=%0d idx=%0d vis=%0b col=%06h last=%0b",
                         gx, gy, d[19:12], d[20], d[44:21], tl);
            end
        end
    endfunction

    // command driver
    always @(posedge i_clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_axis_tready) begin
                walk_line(on_bus);
                lines_accepted++;
                src_gap = next_gap(on_bus.no_gap);
            end
            if ((s_tvalid && o_s_axis_tready) || !s_tvalid) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (line_queue.size() > 0 &&
                             (!line_queue[0].drain || pending_points.size() == 0)) begin
                    on_bus = line_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {on_bus.colour, on_bus.y1, on_bus.x1, on_bus.y0, on_bus.x0};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // point monitor and back-pressure
    always @(posedge i_clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            rx_cycles++;
            if (o_m_axis_tvalid && m_tready) begin
                check_word(o_m_axis_tdata, o_m_axis_tlast);
                words_taken++;
            end
            if (!long_hold_done && words_taken >= 300) begin
                long_hold_done = 1'b1;
                rx_hold = 400;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else begin
                r = $urandom_range(99);
                if ((rx_cycles % 1000) < 200 || r < 70) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    rx_hold = (r < 95) ? $urandom_range(3) : $urandom_range(10, 40);
                end
            end
        end
    end

    // watchdog on handshake activity, unexpected words do not count
    always @(posedge i_clk) begin
        if (!rst_n || (s_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && m_tready && pending_points.size() != 0)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        // single points, on and off the display
        add_line(0, 0, 0, 0, 24'h000000, 1'b0, 1'b0);
        add_line(-32, -32, -32, -32, 24'hFFFFFF, 1'b0, 1'b0);
        add_line(31, 31, 31, 31, 24'hAAAAAA, 1'b0, 1'b0);
        add_line(23, 7, 23, 7, 24'h555555, 1'b0, 1'b0);
        // full-length axis lines
        add_line(-32, 0, 31, 0, 24'h123456, 1'b1, 1'b1);
        add_line(5, -32, 5, 31, 24'hFEDCBA, 1'b1, 1'b0);
        add_line(31, 7, -32, 7, 24'h0000FF, 1'b0, 1'b0);
        add_line(0, 31, 0, -32, 24'h00FF00, 1'b0, 1'b0);
        // equal deltas, y major
        add_line(0, 0, 7, 7, 24'hFF0000, 1'b0, 1'b0);
        add_line(-32, -32, 31, 31, 24'h800001, 1'b1, 1'b0);
        add_line(31, -32, -32, 31, 24'h7FFFFE, 1'b0, 1'b0);
        add_line(7, 0, 0, 7, 24'h010203, 1'b0, 1'b0);
        // shallow and steep lines in various directions
        add_line(23, 7, 0, 0, 24'hC0FFEE, 1'b0, 1'b0);
        add_line(31, 5, -32, 2, 24'hBADA55, 1'b0, 1'b0);
        add_line(3, 31, 0, -32, 24'h0F0F0F, 1'b0, 1'b0);
        add_line(-5, -3, 20, 9, 24'hF0F0F0, 1'b0, 1'b0);
        add_line(2, 10, 6, -6, 24'h3C3C3C, 1'b0, 1'b0);
        // display edges
        add_line(23, 7, 24, 8, 24'hFFFFFF, 1'b0, 1'b0);
        add_line(0, -1, -1, 0, 24'h000001, 1'b0, 1'b0);
        add_line(-1, 8, 24, -1, 24'h800000, 1'b0, 1'b1);
        add_line(8, 0, 15, 7, 24'h112233, 1'b0, 1'b0);

        for (int i = 0; i < N_RANDOM; i++) begin
            int x0;
            int y0;
            int x1;
            int y1;
            int kind;
            kind = $urandom_range(99);
            if (kind < 50) begin
                x0 = pick(-4, 27);
                y0 = pick(-3, 10);
                x1 = pick(-4, 27);
                y1 = pick(-3, 10);
            end else if (kind < 80) begin
                x0 = pick(-32, 31);
                y0 = pick(-32, 31);
                x1 = pick(-32, 31);
                y1 = pick(-32, 31);
            end else begin
                x0 = pick(-32, 31);
                y0 = pick(-32, 31);
                x1 = x0 + pick(-3, 3);
                y1 = y0 + pick(-3, 3);
            end
            add_line(x0, y0, x1, y1, COLOUR_W'($urandom), ((i / 40) % 3) == 0,
                     (i % 100) == 99);
        end

        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;

        while (!(lines_accepted == lines_total && pending_points.size() == 0)) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        if (mismatches == 0 && pending_points.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/blmc_pkg.sv
hw/rtl/blmc_ctrl.sv
hw/rtl/blmc_dp.sv
hw/rtl/bresenham_line_to_led_matrix_core.sv
tb/bresenham_line_to_led_matrix_core_tb.sv
